/* src/bucket_statistics_aggregator_top_assert.svh */
`ifndef BUCKET_STATISTICS_AGGREGATOR_TOP_ASSERT_SVH
`define BUCKET_STATISTICS_AGGREGATOR_TOP_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define BSA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bsa assertion failed");

// next-cycle implication, checked while out of reset
`define BSA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bsa assertion failed");

`endif

/* src/bsa_pkg.sv */
package bsa_pkg;

    localparam int OUT_BITS           = 48;
    localparam int DEF_VALUE_BITS     = 24;
    localparam int DEF_FRAC_BITS      = 12;
    localparam int DEF_COUNT_BITS     = 16;
    localparam int MODE_W             = 4;

    localparam logic [MODE_W-1:0] MODE_MIN   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_MAX   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SUM   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_AVG   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_COUNT = 4'd4;
    localparam logic [MODE_W-1:0] MODE_FIRST = 4'd5;
    localparam logic [MODE_W-1:0] MODE_LAST  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_RANGE = 4'd7;
    localparam logic [MODE_W-1:0] MODE_VARP  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_VARS  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_STDP  = 4'd10;
    localparam logic [MODE_W-1:0] MODE_STDS  = 4'd11;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    typedef struct packed {
        logic start;
        logic avg;
        logic smp;
        logic root;
    } eng_ctl_t;

    localparam logic signed [OUT_BITS-1:0] OUT_POS_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OUT_NEG_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    function automatic logic [OUT_BITS-1:0] sat_s_out(input logic signed [63:0] v);
        if (v > 64'(OUT_POS_MAX)) return OUT_POS_MAX;
        if (v < 64'(OUT_NEG_MIN)) return OUT_NEG_MIN;
        return v[OUT_BITS-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] sat_u_out(input logic [63:0] v);
        if (v > 64'(OUT_POS_MAX)) return OUT_POS_MAX;
        return v[OUT_BITS-1:0];
    endfunction

endpackage

/* src/bsa_engine.sv */
module bsa_engine #(
    parameter int VALUE_BITS = bsa_pkg::DEF_VALUE_BITS,
    parameter int COUNT_BITS = bsa_pkg::DEF_COUNT_BITS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  bsa_pkg::eng_ctl_t                       ctl,
    input  logic [COUNT_BITS-1:0]                   n,
    input  logic signed [VALUE_BITS+COUNT_BITS-1:0] sum,
    input  logic [2*VALUE_BITS+COUNT_BITS-1:0]      sq,
    output logic                                    done,
    output logic [63:0]                             q64,
    output logic [31:0]                             root
);
    import bsa_pkg::*;

    localparam int SUM_W = VALUE_BITS + COUNT_BITS;
    localparam int NW    = 2 * VALUE_BITS + 2 * COUNT_BITS;
    localparam int QW    = (NW > 64) ? NW : 64;
    localparam int DW    = 2 * COUNT_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_MULN = 3'd1;
    localparam logic [2:0] E_MULS = 3'd2;
    localparam logic [2:0] E_SUB  = 3'd3;
    localparam logic [2:0] E_DIV  = 3'd4;
    localparam logic [2:0] E_SQI  = 3'd5;
    localparam logic [2:0] E_SQRT = 3'd6;
    localparam logic [2:0] E_DONE = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  root_reg, root_next;
    logic [NW-1:0]         acc_reg, acc_next;
    logic [NW-1:0]         prod_reg, prod_next;
    logic [NW-1:0]         num_reg, num_next;
    logic [QW-1:0]         q_reg, q_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [DW-1:0]         d_reg, d_next;
    logic [COUNT_BITS-1:0] nsh_reg, nsh_next;
    logic [SUM_W-1:0]      ash_reg, ash_next;
    logic [63:0]           v_reg, v_next;
    logic [63:0]           res_reg, res_next;
    logic [63:0]           bit_reg, bit_next;

    logic [SUM_W-1:0] abs_sum;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic [63:0]      trial;

    assign abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    assign shifted = {rem_reg, num_reg[NW-1]};
    assign diff    = shifted - {1'b0, d_reg};
    assign trial   = res_reg + bit_reg;
    assign q64     = ((q_reg >> 64) != '0) ? '1 : q_reg[63:0];
    assign root    = res_reg[31:0];
    assign done    = (state_reg == E_DONE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        root_next  = root_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        d_next     = d_reg;
        nsh_next   = nsh_reg;
        ash_next   = ash_reg;
        v_next     = v_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        case (state_reg)
            E_IDLE: begin
                if (ctl.start) begin
                    root_next = ctl.root;
                    rem_next  = '0;
                    q_next    = '0;
                    if (ctl.avg) begin
                        num_next   = NW'(abs_sum);
                        d_next     = DW'(n);
                        cnt_next   = CNT_W'(NW);
                        state_next = E_DIV;
                    end else begin
                        acc_next   = '0;
                        nsh_next   = n;
                        d_next     = ctl.smp ? DW'(n) * DW'(n - 1'b1) : DW'(n) * DW'(n);
                        cnt_next   = CNT_W'(COUNT_BITS);
                        state_next = E_MULN;
                    end
                end
            end
            E_MULN: begin
                acc_next = (acc_reg << 1) + (nsh_reg[COUNT_BITS-1] ? NW'(sq) : '0);
                nsh_next = nsh_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    prod_next  = '0;
                    ash_next   = abs_sum;
                    cnt_next   = CNT_W'(SUM_W);
                    state_next = E_MULS;
                end
            end
            E_MULS: begin
                prod_next = (prod_reg << 1) + (ash_reg[SUM_W-1] ? NW'(abs_sum) : '0);
                ash_next  = ash_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = E_SUB;
                end
            end
            E_SUB: begin
                num_next   = acc_reg - prod_reg;
                cnt_next   = CNT_W'(NW);
                state_next = E_DIV;
            end
            E_DIV: begin
                if (!diff[DW]) begin
                    rem_next = diff[DW-1:0];
                    q_next   = {q_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next = shifted[DW-1:0];
                    q_next   = {q_reg[QW-2:0], 1'b0};
                end
                num_next = num_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = root_reg ? E_SQI : E_DONE;
                end
            end
            E_SQI: begin
                v_next     = q64;
                res_next   = '0;
                bit_next   = 64'd1 << 62;
                state_next = E_SQRT;
            end
            E_SQRT: begin
                if (v_reg >= trial) begin
                    v_next   = v_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if ((bit_reg >> 2) == '0) begin
                    state_next = E_DONE;
                end
            end
            E_DONE: begin
                state_next = E_IDLE;
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg  <= cnt_next;
        root_reg <= root_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        d_reg    <= d_next;
        nsh_reg  <= nsh_next;
        ash_reg  <= ash_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
    end

endmodule

/* src/bucket_statistics_aggregator_top.sv */
// Bucket statistics aggregator.
// s_ channel: tdata carries a signed sample (Q.FRAC_BITS), tuser the opcode
// (0 add sample, 1 close bucket). m_ channel: tdata carries the aggregate,
// tuser its flags. One result transaction per close, none per add.
// agg_mode is written through cfg_wr_en/cfg_wr_data while the block is idle;
// the user must ensure this, the block does not enforce it. An add registers
// the square, then accumulates, stalling the input meanwhile. A close for min,
// max, sum, count, first, last, range, an empty bucket or one-sample VARS/STDS
// loads the output register in the accept cycle. Average and variance share
// the restoring divider, variance after COUNT_BITS + VALUE_BITS+COUNT_BITS
// shift-add multiply steps; standard deviation adds a square root after it.
// Reset clears the bucket, the last value and agg_mode; there is no clearing
// pass. While a result waits in the output register the input is stalled.
module bucket_statistics_aggregator_top #(
    parameter int VALUE_BITS = bsa_pkg::DEF_VALUE_BITS,
    parameter int FRAC_BITS  = bsa_pkg::DEF_FRAC_BITS,
    parameter int COUNT_BITS = bsa_pkg::DEF_COUNT_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [bsa_pkg::MODE_W-1:0]            cfg_wr_data,  // agg_mode
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]       s_tdata,      // sample_value
    input  logic                                  s_tuser,      // opcode
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bsa_pkg::OUT_BITS-1:0]          m_tdata,      // agg_value
    output logic [1:0]                            m_tuser       // [1] count_overflow, [0] is_nan
);
    import bsa_pkg::*;

    localparam int SUM_W = VALUE_BITS + COUNT_BITS;
    localparam int SQ_W  = 2 * VALUE_BITS + COUNT_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;

    localparam logic signed [VALUE_BITS-1:0] MIN_INIT = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] MAX_INIT = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0]        CNT_MAX  = '1;

    logic [1:0]                    state_reg, state_next;
    logic [MODE_W-1:0]             mode_reg;
    logic [COUNT_BITS-1:0]         count_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]               sq_reg;
    logic signed [VALUE_BITS-1:0]  min_reg, max_reg, first_reg, last_reg, samp_reg;
    logic                          first_taken_reg, ovf_reg;
    logic [2*VALUE_BITS-1:0]       sqp_reg;
    logic                          m_valid_reg;
    logic [OUT_BITS-1:0]           m_data_reg;
    logic                          m_nan_reg, m_ovf_reg;

    logic                          accept, is_close, empty, use_eng, smp, load_out;
    logic signed [VALUE_BITS-1:0]  s_val;
    logic [VALUE_BITS-1:0]         s_mag;
    logic signed [VALUE_BITS:0]    range_val;
    logic [OUT_BITS-1:0]           simple_val, eng_val, out_val;
    logic                          nan_mode;
    eng_ctl_t                      ctl;
    logic                          eng_done;
    logic [63:0]                   eng_q;
    logic [31:0]                   eng_root;

    assign s_tready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign is_close  = (s_tuser == OP_CLOSE);
    assign s_val     = s_tdata[VALUE_BITS-1:0];
    assign s_mag     = s_val[VALUE_BITS-1] ? VALUE_BITS'(-s_val) : VALUE_BITS'(s_val);
    assign empty     = (count_reg == '0);
    assign smp       = (mode_reg == MODE_VARS) || (mode_reg == MODE_STDS);
    assign range_val = (VALUE_BITS+1)'(max_reg) - (VALUE_BITS+1)'(min_reg);

    assign nan_mode = empty && ((mode_reg == MODE_MIN) || (mode_reg == MODE_MAX) ||
                      (mode_reg == MODE_AVG) || (mode_reg == MODE_FIRST) ||
                      (mode_reg == MODE_RANGE) || (mode_reg == MODE_VARP) ||
                      (mode_reg == MODE_VARS) || (mode_reg == MODE_STDP) ||
                      (mode_reg == MODE_STDS));

    assign use_eng = !empty && ((mode_reg == MODE_AVG) ||
                     (((mode_reg == MODE_VARP) || (mode_reg == MODE_VARS) ||
                       (mode_reg == MODE_STDP) || (mode_reg == MODE_STDS)) &&
                      !(smp && count_reg == COUNT_BITS'(1))));

    assign ctl.start = accept && is_close && use_eng;
    assign ctl.avg   = (mode_reg == MODE_AVG);
    assign ctl.smp   = smp;
    assign ctl.root  = (mode_reg == MODE_STDP) || (mode_reg == MODE_STDS);

    always_comb begin
        simple_val = '0;
        if (!nan_mode) begin
            case (mode_reg)
                MODE_MIN:   simple_val = OUT_BITS'(min_reg);
                MODE_MAX:   simple_val = OUT_BITS'(max_reg);
                MODE_SUM:   simple_val = sat_s_out(64'(sum_reg));
                MODE_COUNT: simple_val = sat_u_out(64'(count_reg) << FRAC_BITS);
                MODE_FIRST: simple_val = OUT_BITS'(first_reg);
                MODE_LAST:  simple_val = OUT_BITS'(last_reg);
                MODE_RANGE: simple_val = OUT_BITS'(range_val);
                default:    simple_val = '0;
            endcase
        end
    end

    always_comb begin
        case (mode_reg)
            MODE_AVG:  eng_val = sat_s_out(sum_reg[SUM_W-1] ?
                                 -64'(eng_q[SUM_W-1:0]) : 64'(eng_q[SUM_W-1:0]));
            MODE_VARP,
            MODE_VARS: eng_val = sat_u_out(eng_q >> FRAC_BITS);
            default:   eng_val = sat_u_out(64'(eng_root));
        endcase
    end

    assign load_out = (accept && is_close && !use_eng) || (state_reg == ST_CALC && eng_done);
    assign out_val  = (state_reg == ST_CALC) ? eng_val : simple_val;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!is_close) begin
                        state_next = ST_SQ;
                    end else if (use_eng) begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_SQ:   state_next = ST_IDLE;
            ST_CALC: begin
                if (eng_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mode_reg        <= MODE_MIN;
            count_reg       <= '0;
            sum_reg         <= '0;
            sq_reg          <= '0;
            min_reg         <= MIN_INIT;
            max_reg         <= MAX_INIT;
            first_reg       <= '0;
            first_taken_reg <= 1'b0;
            last_reg        <= '0;
            ovf_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (state_reg == ST_SQ) begin
                if (samp_reg > max_reg) max_reg <= samp_reg;
                if (samp_reg < min_reg) min_reg <= samp_reg;
                if (!first_taken_reg) begin
                    first_reg       <= samp_reg;
                    first_taken_reg <= 1'b1;
                end
                last_reg <= samp_reg;
                if (count_reg == CNT_MAX) begin
                    ovf_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + SUM_W'(samp_reg);
                    sq_reg    <= sq_reg + SQ_W'(sqp_reg);
                end
            end
            if (load_out) begin
                m_valid_reg     <= 1'b1;
                count_reg       <= '0;
                sum_reg         <= '0;
                sq_reg          <= '0;
                min_reg         <= MIN_INIT;
                max_reg         <= MAX_INIT;
                first_reg       <= '0;
                first_taken_reg <= 1'b0;
                ovf_reg         <= 1'b0;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept && !is_close) begin
            samp_reg <= s_val;
            sqp_reg  <= s_mag * s_mag;
        end
        if (load_out) begin
            m_data_reg <= out_val;
            m_nan_reg  <= nan_mode;
            m_ovf_reg  <= ovf_reg;
        end
    end

    bsa_engine #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .n       (count_reg),
        .sum     (sum_reg),
        .sq      (sq_reg),
        .done    (eng_done),
        .q64     (eng_q),
        .root    (eng_root)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_ovf_reg, m_nan_reg};

`include "bucket_statistics_aggregator_top_assert.svh"

    `BSA_ASSERT_NXT(a_calc_done_out, (state_reg == ST_CALC) && eng_done, m_tvalid)
    `BSA_ASSERT_NXT(a_empty_min_nan,
        accept && is_close && empty && (mode_reg == MODE_MIN), m_tuser[0] && m_tdata == '0)
    `BSA_ASSERT_NXT(a_add_count_up, state_reg == ST_SQ, count_reg >= $past(count_reg))
    `BSA_ASSERT_IMP(a_no_accept_busy, state_reg != ST_IDLE, !s_tready)

endmodule
